FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the scan sequencer RTL.
// No dependencies; the checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RPSS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rpss assertion failed");
`define RPSS_ASSERT_ALWAYS(lbl, clk, expr) \
    lbl: assert property (@(posedge clk) expr) \
        else $error("rpss invariant failed");
`else
`define RPSS_ASSERT(lbl, clk, rst_n, prop)
`define RPSS_ASSERT_ALWAYS(lbl, clk, expr)
`endif
`endif

FILE: rtl/core/rpss_pkg.sv
// Shared types, codes and helpers for the resistive pad scan sequencer.
// No dependencies.
`default_nettype none
package rpss_pkg;

    typedef logic [2:0] phase_t;

    localparam phase_t PH_PRESS_A = 3'd0;
    localparam phase_t PH_PRESS_B = 3'd1;
    localparam phase_t PH_PRESS_C = 3'd2;
    localparam phase_t PH_PRESS_D = 3'd3;
    localparam phase_t PH_X       = 3'd4;
    localparam phase_t PH_Y       = 3'd5;

    typedef logic [1:0] drive_t;

    localparam drive_t DRV_PRESS_A = 2'd0;
    localparam drive_t DRV_PRESS_B = 2'd1;
    localparam drive_t DRV_X       = 2'd2;
    localparam drive_t DRV_Y       = 2'd3;

    typedef logic [1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_THRESHOLD = 2'd0;
    localparam cfg_idx_t CFG_VEL_TMO   = 2'd1;
    localparam cfg_idx_t CFG_REL_DEB   = 2'd2;
    localparam cfg_idx_t CFG_FULLSCALE = 2'd3;

    typedef struct packed {
        logic [15:0] threshold;
        logic [15:0] vel_timeout;
        logic [15:0] rel_debounce;
        logic [11:0] full_scale;
    } rpss_cfg_t;

    // One kept sample handed from the sequencer to the pad bank.
    typedef struct packed {
        logic   en;
        phase_t phase;
    } rpss_step_t;

    typedef struct packed {
        logic        done;
        logic [15:0] velocity;
        logic [15:0] pressure;
        logic [11:0] x;
        logic [11:0] y;
    } rpss_rec_t;

    function automatic drive_t drive_for_phase(input phase_t ph);
        drive_t d;
        case (ph)
            PH_PRESS_C, PH_PRESS_D: d = DRV_PRESS_B;
            PH_X:                   d = DRV_X;
            PH_Y:                   d = DRV_Y;
            default:                d = DRV_PRESS_A;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/rpss_seq.sv
// Phase sequencer: discard toggle, read phase, active pad and plate reading.
// Depends on rpss_pkg.
`default_nettype none
module rpss_seq
    import rpss_pkg::*;
#(
    parameter int PAD_COUNT = 9,
    parameter int PAD_W     = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             proc_fire,
    input  wire logic [11:0]      sample,
    output rpss_step_t            step,
    output logic [PAD_W-1:0]      pad_idx,
    output logic [11:0]           plate,
    output phase_t                phase_next,
    output logic [PAD_W-1:0]      pad_next
);

    logic             toggle_reg;
    phase_t           phase_reg;
    logic [PAD_W-1:0] pad_reg;
    logic [11:0]      plate_reg;
    logic             kept;

    // The toggle flips on every sample; a sample is kept when it returns to zero.
    assign kept = proc_fire && toggle_reg;

    always_comb begin
        phase_next = phase_reg;
        pad_next   = pad_reg;
        if (kept) begin
            case (phase_reg)
                PH_PRESS_A: phase_next = PH_PRESS_B;
                PH_PRESS_B: phase_next = PH_PRESS_C;
                PH_PRESS_C: phase_next = PH_PRESS_D;
                PH_PRESS_D: phase_next = PH_X;
                PH_X:       phase_next = PH_Y;
                PH_Y: begin
                    phase_next = PH_PRESS_A;
                    pad_next   = (pad_reg == PAD_W'(PAD_COUNT - 1)) ? '0 : pad_reg + 1'b1;
                end
                default:    phase_next = PH_PRESS_A;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            toggle_reg <= 1'b0;
            phase_reg  <= PH_PRESS_A;
            pad_reg    <= '0;
            plate_reg  <= '0;
        end else begin
            if (proc_fire) begin
                toggle_reg <= ~toggle_reg;
            end
            phase_reg <= phase_next;
            pad_reg   <= pad_next;
            if (kept && (phase_reg == PH_PRESS_A || phase_reg == PH_PRESS_C)) begin
                plate_reg <= sample;
            end
        end
    end

    assign step.en    = kept;
    assign step.phase = phase_reg;
    assign pad_idx    = pad_reg;
    assign plate      = plate_reg;

endmodule
`default_nettype wire

FILE: rtl/core/rpss_pad_bank.sv
// Per-pad record bank: pressure judging, velocity and release timers, record readout.
// Depends on rpss_pkg.
`default_nettype none
module rpss_pad_bank
    import rpss_pkg::*;
#(
    parameter int PAD_COUNT = 9,
    parameter int PAD_W     = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire rpss_cfg_t        cfg,
    input  wire rpss_step_t       step,
    input  wire logic [PAD_W-1:0] pad_idx,
    input  wire logic [11:0]      plate,
    input  wire logic [11:0]      sample,
    input  wire logic [31:0]      now_ms,
    output rpss_rec_t             rec
);

    logic [15:0] vel_store_reg   [PAD_COUNT];
    logic [15:0] press_store_reg [PAD_COUNT];
    logic [11:0] x_store_reg     [PAD_COUNT];
    logic [11:0] y_store_reg     [PAD_COUNT];
    logic        vel_started_reg [PAD_COUNT];
    logic        rel_started_reg [PAD_COUNT];
    logic [31:0] vel_start_reg   [PAD_COUNT];
    logic [31:0] rel_start_reg   [PAD_COUNT];

    logic [15:0] half;
    logic [15:0] sum;
    logic        pressed;
    logic        vel_due;
    logic        rel_due;

    logic [15:0] vel_next;
    logic [15:0] press_next;
    logic [11:0] x_next;
    logic [11:0] y_next;
    logic        vel_started_next;
    logic        rel_started_next;
    logic [31:0] vel_start_next;
    logic [31:0] rel_start_next;

    // Pressure half: full scale minus the plate difference, wrapping at 16 bits.
    assign half    = {4'd0, cfg.full_scale} - {4'd0, sample} + {4'd0, plate};
    assign sum     = press_store_reg[pad_idx] + half;
    assign pressed = sum > cfg.threshold;
    assign vel_due = (now_ms - vel_start_reg[pad_idx]) >= {16'd0, cfg.vel_timeout};
    assign rel_due = (now_ms - rel_start_reg[pad_idx]) >= {16'd0, cfg.rel_debounce};

    always_comb begin
        vel_next         = vel_store_reg[pad_idx];
        press_next       = press_store_reg[pad_idx];
        x_next           = x_store_reg[pad_idx];
        y_next           = y_store_reg[pad_idx];
        vel_started_next = vel_started_reg[pad_idx];
        rel_started_next = rel_started_reg[pad_idx];
        vel_start_next   = vel_start_reg[pad_idx];
        rel_start_next   = rel_start_reg[pad_idx];
        case (step.phase)
            PH_PRESS_B: press_next = half;
            PH_PRESS_D: begin
                if (pressed) begin
                    rel_started_next = 1'b0;
                    rel_start_next   = '0;
                    press_next       = sum;
                    if (vel_store_reg[pad_idx] == '0) begin
                        if (!vel_started_reg[pad_idx]) begin
                            vel_started_next = 1'b1;
                            vel_start_next   = now_ms;
                        end else if (vel_due) begin
                            vel_next = sum;
                        end
                    end
                end else if (vel_store_reg[pad_idx] != '0) begin
                    if (!rel_started_reg[pad_idx]) begin
                        rel_started_next = 1'b1;
                        rel_start_next   = now_ms;
                    end else if (rel_due) begin
                        // Released long enough: clear the record, keep the release timer.
                        vel_started_next = 1'b0;
                        vel_start_next   = '0;
                        vel_next         = '0;
                        press_next       = '0;
                        x_next           = '0;
                        y_next           = '0;
                    end
                end
            end
            PH_X:       x_next = sample;
            PH_Y:       y_next = sample;
            default:    ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PAD_COUNT; i++) begin
                vel_store_reg[i]   <= '0;
                press_store_reg[i] <= '0;
                x_store_reg[i]     <= '0;
                y_store_reg[i]     <= '0;
                vel_started_reg[i] <= 1'b0;
                rel_started_reg[i] <= 1'b0;
            end
        end else if (step.en) begin
            vel_store_reg[pad_idx]   <= vel_next;
            press_store_reg[pad_idx] <= press_next;
            x_store_reg[pad_idx]     <= x_next;
            y_store_reg[pad_idx]     <= y_next;
            vel_started_reg[pad_idx] <= vel_started_next;
            rel_started_reg[pad_idx] <= rel_started_next;
        end
    end

    // Start times are only read while their started bit is set.
    always_ff @(posedge aclk) begin
        if (step.en) begin
            vel_start_reg[pad_idx] <= vel_start_next;
            rel_start_reg[pad_idx] <= rel_start_next;
        end
    end

    always_comb begin
        rec = '0;
        if (step.en && step.phase == PH_Y) begin
            rec.done     = 1'b1;
            rec.velocity = vel_store_reg[pad_idx];
            rec.pressure = press_store_reg[pad_idx];
            rec.x        = x_store_reg[pad_idx];
            rec.y        = sample;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/resistive_pad_scan_sequencer_core.sv
// A request accepted into the input register is loaded into the result register when
// that register is empty or being taken, and the receiver takes its result from there.
// Throughput: one request per cycle while the receiver takes results; a result stall
// holds the result register, then the input register and s_ready, and each request's update is one shallow pass.
// Reset (aresetn, synchronous, active low) clears phase, toggle, pad and all pad
// records and loads the register defaults; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"
module resistive_pad_scan_sequencer_core
    import rpss_pkg::*;
#(
    parameter int PAD_COUNT = 9
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [11:0] s_adc_sample,
    input  wire logic [31:0] s_now_ms,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_drive_setup,
    output logic [2:0]       m_channel_slot,
    output logic [3:0]       m_mux_select,
    output logic             m_pad_done,
    output logic [3:0]       m_pad_index,
    output logic [15:0]      m_pad_velocity,
    output logic [15:0]      m_pad_pressure,
    output logic [11:0]      m_pad_x,
    output logic [11:0]      m_pad_y
);

    localparam int PAD_W = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

    rpss_cfg_t        cfg_reg;
    logic             in_vld_reg;
    logic [11:0]      in_sample_reg;
    logic [31:0]      in_now_reg;
    logic             out_vld_reg;
    drive_t           out_drive_reg;
    phase_t           out_slot_reg;
    logic [3:0]       out_mux_reg;
    logic [3:0]       out_index_reg;
    rpss_rec_t        out_rec_reg;

    logic             proc_fire;
    logic             s_accept;
    rpss_step_t       step;
    logic [PAD_W-1:0] pad_idx;
    logic [11:0]      plate;
    phase_t           phase_next;
    logic [PAD_W-1:0] pad_next;
    rpss_rec_t        rec;

    assign proc_fire = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || proc_fire;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold    <= 16'd50;
            cfg_reg.vel_timeout  <= 16'd5;
            cfg_reg.rel_debounce <= 16'd50;
            cfg_reg.full_scale   <= 12'd4095;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_THRESHOLD: cfg_reg.threshold    <= cfg_data;
                CFG_VEL_TMO:   cfg_reg.vel_timeout  <= cfg_data;
                CFG_REL_DEB:   cfg_reg.rel_debounce <= cfg_data;
                CFG_FULLSCALE: cfg_reg.full_scale   <= cfg_data[11:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                in_vld_reg <= 1'b1;
            end else if (proc_fire) begin
                in_vld_reg <= 1'b0;
            end
            if (proc_fire) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_sample_reg <= s_adc_sample;
            in_now_reg    <= s_now_ms;
        end
        if (proc_fire) begin
            out_drive_reg <= drive_for_phase(phase_next);
            out_slot_reg  <= phase_next;
            out_mux_reg   <= 4'(pad_next);
            out_index_reg <= rec.done ? 4'(pad_idx) : 4'd0;
            out_rec_reg   <= rec;
        end
    end

    rpss_seq #(
        .PAD_COUNT (PAD_COUNT),
        .PAD_W     (PAD_W)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .proc_fire  (proc_fire),
        .sample     (in_sample_reg),
        .step       (step),
        .pad_idx    (pad_idx),
        .plate      (plate),
        .phase_next (phase_next),
        .pad_next   (pad_next)
    );

    rpss_pad_bank #(
        .PAD_COUNT (PAD_COUNT),
        .PAD_W     (PAD_W)
    ) u_bank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .step    (step),
        .pad_idx (pad_idx),
        .plate   (plate),
        .sample  (in_sample_reg),
        .now_ms  (in_now_reg),
        .rec     (rec)
    );

    assign m_valid        = out_vld_reg;
    assign m_drive_setup  = out_drive_reg;
    assign m_channel_slot = out_slot_reg;
    assign m_mux_select   = out_mux_reg;
    assign m_pad_done     = out_rec_reg.done;
    assign m_pad_index    = out_index_reg;
    assign m_pad_velocity = out_rec_reg.velocity;
    assign m_pad_pressure = out_rec_reg.pressure;
    assign m_pad_x        = out_rec_reg.x;
    assign m_pad_y        = out_rec_reg.y;

    // A finished pad always leaves the sequencer at the first pressure phase.
    `RPSS_ASSERT(a_done_restarts_phase, aclk, aresetn, (m_valid && m_pad_done) |-> (m_channel_slot == PH_PRESS_A))
    // Results without a finished pad carry an empty record.
    `RPSS_ASSERT(a_idle_record_zero, aclk, aresetn, (m_valid && !m_pad_done) |-> (m_pad_index == 4'd0 && m_pad_velocity == 16'd0 && m_pad_pressure == 16'd0 && m_pad_x == 12'd0 && m_pad_y == 12'd0))
    // A buffered request that cannot move on is kept intact.
    `RPSS_ASSERT(a_input_held, aclk, aresetn, (in_vld_reg && !proc_fire) |=> (in_vld_reg && $stable(in_sample_reg) && $stable(in_now_reg)))
    // The multiplexer never selects a pad beyond the configured count.
    `RPSS_ASSERT(a_mux_in_range, aclk, aresetn, m_valid |-> (m_mux_select <= 4'(PAD_COUNT - 1)))

endmodule
`default_nettype wire

FILE: bench/resistive_pad_scan_sequencer_core_chk.sv
// Checker for the resistive pad scan sequencer: watches the register, sample and
// result channels, predicts every result and compares it field by field.
// Depends on rpss_pkg for the phase, drive and register index codes.
module resistive_pad_scan_sequencer_core_chk
    import rpss_pkg::*;
#(
    parameter int PADS = 9
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [11:0] s_adc_sample,
    input  wire logic [31:0] s_now_ms,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [1:0]  m_drive_setup,
    input  wire logic [2:0]  m_channel_slot,
    input  wire logic [3:0]  m_mux_select,
    input  wire logic        m_pad_done,
    input  wire logic [3:0]  m_pad_index,
    input  wire logic [15:0] m_pad_velocity,
    input  wire logic [15:0] m_pad_pressure,
    input  wire logic [11:0] m_pad_x,
    input  wire logic [11:0] m_pad_y,
    output int unsigned      mismatches,
    output int unsigned      outstanding,
    output int unsigned      checked,
    output int unsigned      strikes
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0] DEF_THRESHOLD  = 16'd50;
    localparam logic [15:0] DEF_VEL_TMO    = 16'd5;
    localparam logic [15:0] DEF_REL_DEB    = 16'd50;
    localparam logic [11:0] DEF_FULL_SCALE = 12'd4095;

    typedef struct packed {
        drive_t      drive;
        phase_t      slot;
        logic [3:0]  mux;
        logic        done;
        logic [3:0]  index;
        logic [15:0] velocity;
        logic [15:0] pressure;
        logic [11:0] x;
        logic [11:0] y;
    } scan_report_t;

    rpss_cfg_t   regs;
    logic        toggle;
    phase_t      phase;
    logic [3:0]  pad;
    logic [15:0] plate;
    logic [31:0] vel_t0    [PADS];
    logic [31:0] rel_t0    [PADS];
    logic        vel_armed [PADS];
    logic        rel_armed [PADS];
    logic [15:0] velocity  [PADS];
    logic [15:0] pressure  [PADS];
    logic [11:0] pos_x     [PADS];
    logic [11:0] pos_y     [PADS];

    scan_report_t reports_due[$];

    // One half of the pressure reading: full scale minus the plate rise, mod 2^16.
    function automatic logic [15:0] plate_half(input logic [11:0] second);
        return {4'd0, regs.full_scale} - ({4'd0, second} - plate);
    endfunction

    task automatic weigh_press(input int p, input logic [15:0] sum, input logic [31:0] now);
        if (sum > regs.threshold) begin
            rel_armed[p] = 1'b0;
            if (velocity[p] == 16'd0) begin
                if (!vel_armed[p]) begin
                    vel_armed[p] = 1'b1;
                    vel_t0[p] = now;
                end else if (now - vel_t0[p] >= {16'd0, regs.vel_timeout}) begin
                    velocity[p] = sum;
                end
            end
            pressure[p] = sum;
        end else if (velocity[p] != 16'd0) begin
            if (!rel_armed[p]) begin
                rel_armed[p] = 1'b1;
                rel_t0[p] = now;
            end else if (now - rel_t0[p] >= {16'd0, regs.rel_debounce}) begin
                // The release timer deliberately stays armed after the clear.
                vel_armed[p] = 1'b0;
                velocity[p] = 16'd0;
                pressure[p] = 16'd0;
                pos_x[p] = 12'd0;
                pos_y[p] = 12'd0;
            end
        end
    endtask

    task automatic predict_scan(input logic [11:0] sample, input logic [31:0] now);
        scan_report_t r;
        int p;
        logic [15:0] sum;
        r = '0;
        p = int'(pad);
        toggle = ~toggle;
        if (!toggle) begin
            case (phase)
                PH_PRESS_A: begin
                    plate = {4'd0, sample};
                    phase = PH_PRESS_B;
                end
                PH_PRESS_B: begin
                    pressure[p] = plate_half(sample);
                    phase = PH_PRESS_C;
                end
                PH_PRESS_C: begin
                    plate = {4'd0, sample};
                    phase = PH_PRESS_D;
                end
                PH_PRESS_D: begin
                    sum = pressure[p] + plate_half(sample);
                    weigh_press(p, sum, now);
                    phase = PH_X;
                end
                PH_X: begin
                    pos_x[p] = sample;
                    phase = PH_Y;
                end
                PH_Y: begin
                    pos_y[p] = sample;
                    phase = PH_PRESS_A;
                    r.done = 1'b1;
                    r.index = pad;
                    r.velocity = velocity[p];
                    r.pressure = pressure[p];
                    r.x = pos_x[p];
                    r.y = pos_y[p];
                    pad = (p + 1 >= PADS) ? 4'd0 : 4'(p + 1);
                end
                default: begin
                    phase = PH_PRESS_A;
                end
            endcase
        end
        if (phase < PH_PRESS_C) begin
            r.drive = DRV_PRESS_A;
        end else if (phase < PH_X) begin
            r.drive = DRV_PRESS_B;
        end else if (phase == PH_X) begin
            r.drive = DRV_X;
        end else if (phase == PH_Y) begin
            r.drive = DRV_Y;
        end else begin
            r.drive = DRV_PRESS_A;
        end
        r.slot = phase;
        r.mux = pad;
        reports_due.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : scoreboard
        scan_report_t want;
        if (!aresetn) begin
            regs.threshold = DEF_THRESHOLD;
            regs.vel_timeout = DEF_VEL_TMO;
            regs.rel_debounce = DEF_REL_DEB;
            regs.full_scale = DEF_FULL_SCALE;
            toggle = 1'b0;
            phase = PH_PRESS_A;
            pad = 4'd0;
            plate = 16'd0;
            for (int i = 0; i < PADS; i++) begin
                vel_t0[i] = '0;
                rel_t0[i] = '0;
                vel_armed[i] = 1'b0;
                rel_armed[i] = 1'b0;
                velocity[i] = '0;
                pressure[i] = '0;
                pos_x[i] = '0;
                pos_y[i] = '0;
            end
            reports_due.delete();
            mismatches = 0;
            checked = 0;
            strikes = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_THRESHOLD: regs.threshold = cfg_data;
                    CFG_VEL_TMO:   regs.vel_timeout = cfg_data;
                    CFG_REL_DEB:   regs.rel_debounce = cfg_data;
                    CFG_FULLSCALE: regs.full_scale = cfg_data[11:0];
                    default: ;
                endcase
            end
            // Compare before predicting, so a request accepted at this edge can
            // never be matched by a result leaving at the same edge.
            if (m_valid && m_ready) begin
                if (reports_due.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result with nothing expected, slot %0d, mux %0d",
                             $time, m_channel_slot, m_mux_select);
                end else begin
                    want = reports_due.pop_front();
                    check_field("drive_setup", want.drive, m_drive_setup);
                    check_field("channel_slot", want.slot, m_channel_slot);
                    check_field("mux_select", want.mux, m_mux_select);
                    check_field("pad_done", want.done, m_pad_done);
                    check_field("pad_index", want.index, m_pad_index);
                    check_field("pad_velocity", want.velocity, m_pad_velocity);
                    check_field("pad_pressure", want.pressure, m_pad_pressure);
                    check_field("pad_x", want.x, m_pad_x);
                    check_field("pad_y", want.y, m_pad_y);
                    checked++;
                    if (want.done && want.velocity != 16'd0) begin
                        strikes++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_scan(s_adc_sample, s_now_ms);
            end
        end
        outstanding = reports_due.size();
    end

endmodule

FILE: bench/resistive_pad_scan_sequencer_core_tb.sv
// Top of the scan sequencer testbench: clock, reset, register writes, sample
// stimulus and result back-pressure, plus the final verdict.
// Depends on rpss_pkg, the block and resistive_pad_scan_sequencer_core_chk.
module resistive_pad_scan_sequencer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rpss_pkg::*;

    localparam int PADS = 9;
    localparam int SCAN_LEN = 12;
    localparam int LONG_HOLD = 300;
    // Kept samples of the two directed scans: a pressed pad, then a lifted one.
    localparam logic [0:11][11:0] DIRECTED_KEPT = {
        12'd0, 12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd0,
        12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095
    };

    typedef enum int {SCAN_PRESSED, SCAN_LIFTED, SCAN_EDGE, SCAN_NOISE} scan_kind_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = CFG_THRESHOLD;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic [11:0] s_adc_sample = '0;
    logic [31:0] s_now_ms = '0;
    logic        m_ready = 1'b0;
    wire logic        cfg_ready;
    wire logic        s_ready;
    wire logic        m_valid;
    wire logic [1:0]  m_drive_setup;
    wire logic [2:0]  m_channel_slot;
    wire logic [3:0]  m_mux_select;
    wire logic        m_pad_done;
    wire logic [3:0]  m_pad_index;
    wire logic [15:0] m_pad_velocity;
    wire logic [15:0] m_pad_pressure;
    wire logic [11:0] m_pad_x;
    wire logic [11:0] m_pad_y;
    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned checked;
    int unsigned strikes;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        long_hold_req = 1'b0;
    int unsigned items_sent = 0;
    int unsigned phases_run = 0;
    logic [31:0] clock_ms = '0;
    logic [15:0] cur_threshold = 16'd50;
    logic [11:0] cur_full_scale = 12'd4095;
    scan_kind_t  scan_mode = SCAN_PRESSED;
    scan_kind_t  pad_mode [PADS];
    logic [11:0] plates [4];

    resistive_pad_scan_sequencer_core #(
        .PAD_COUNT(PADS)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_adc_sample(s_adc_sample),
        .s_now_ms(s_now_ms),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_drive_setup(m_drive_setup),
        .m_channel_slot(m_channel_slot),
        .m_mux_select(m_mux_select),
        .m_pad_done(m_pad_done),
        .m_pad_index(m_pad_index),
        .m_pad_velocity(m_pad_velocity),
        .m_pad_pressure(m_pad_pressure),
        .m_pad_x(m_pad_x),
        .m_pad_y(m_pad_y)
    );

    resistive_pad_scan_sequencer_core_chk #(
        .PADS(PADS)
    ) u_chk (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_adc_sample(s_adc_sample),
        .s_now_ms(s_now_ms),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_drive_setup(m_drive_setup),
        .m_channel_slot(m_channel_slot),
        .m_mux_select(m_mux_select),
        .m_pad_done(m_pad_done),
        .m_pad_index(m_pad_index),
        .m_pad_velocity(m_pad_velocity),
        .m_pad_pressure(m_pad_pressure),
        .m_pad_x(m_pad_x),
        .m_pad_y(m_pad_y),
        .mismatches(mismatches),
        .outstanding(outstanding),
        .checked(checked),
        .strikes(strikes)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    task automatic offer_sample(input logic [11:0] sample, input logic [31:0] stamp);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_adc_sample <= sample;
        s_now_ms <= stamp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    // Picks a plate pair whose pressure half comes out as want_half, when the
    // current full scale lets a 12-bit pair reach it; otherwise any pair.
    task automatic make_pair(input int want_half, output logic [11:0] first,
                             output logic [11:0] second);
        int diff;
        int lo;
        int hi;
        diff = int'(cur_full_scale) - want_half;
        if (diff < -4095 || diff > 4095) begin
            first = 12'($urandom_range(0, 4095));
            second = 12'($urandom_range(0, 4095));
        end else begin
            lo = (diff < 0) ? -diff : 0;
            hi = (diff > 0) ? 4095 - diff : 4095;
            first = 12'($urandom_range(lo, hi));
            second = 12'(int'(first) + diff);
        end
    endtask

    // Each pad keeps its touch state over several visits, so the velocity and
    // release timers get to run out rather than being reset every scan.
    task automatic plan_scan();
        int pad;
        int pick;
        int half_lo;
        int h1;
        int h2;
        pad = (items_sent / SCAN_LEN) % PADS;
        if ($urandom_range(0, 99) < 35) begin
            pick = $urandom_range(0, 9);
            pad_mode[pad] = (pick < 4) ? SCAN_PRESSED : (pick < 8) ? SCAN_LIFTED :
                            (pick < 9) ? SCAN_EDGE : SCAN_NOISE;
        end
        scan_mode = pad_mode[pad];
        half_lo = int'(cur_threshold) / 2;
        case (scan_mode)
            SCAN_PRESSED: begin
                h1 = half_lo + int'($urandom_range(1, 1500));
                h2 = half_lo + int'($urandom_range(1, 1500));
            end
            SCAN_LIFTED: begin
                h1 = int'($urandom_range(0, half_lo));
                h2 = int'($urandom_range(0, half_lo));
            end
            default: begin
                h1 = half_lo + int'($urandom_range(0, 2)) - 1;
                h2 = half_lo;
            end
        endcase
        make_pair(h1, plates[0], plates[1]);
        make_pair(h2, plates[2], plates[3]);
    endtask

    task automatic feed_scan_item();
        int slot;
        int pick;
        logic [11:0] sample;
        slot = items_sent % SCAN_LEN;
        if (slot == 0) begin
            plan_scan();
        end
        // Even slots are thrown away by the block; the last two kept ones are X and Y.
        if (slot % 2 == 0 || slot > 8 || scan_mode == SCAN_NOISE) begin
            sample = 12'($urandom_range(0, 4095));
        end else begin
            sample = plates[slot / 2];
        end
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            clock_ms = $urandom();
        end else if (pick < 6) begin
            clock_ms += $urandom_range(0, 70000);
        end else begin
            clock_ms += $urandom_range(0, 2);
        end
        offer_sample(sample, clock_ms);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
        case (idx)
            CFG_THRESHOLD: cur_threshold = value;
            CFG_FULLSCALE: cur_full_scale = value[11:0];
            default: ;
        endcase
    endtask

    task automatic run_phase(input int count, input int unsigned idle_pct,
                             input int unsigned stall_pct, input bit with_hold);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < count; k++) begin
            if (with_hold && k == 30) begin
                long_hold_req = 1'b1;
            end
            feed_scan_item();
        end
        settle();
        phases_run++;
    endtask

    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    initial begin : stimulus
        for (int i = 0; i < PADS; i++) begin
            pad_mode[i] = SCAN_PRESSED;
        end
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Two scans at the code extremes, with the timestamp wrapping through zero.
        for (int n = 0; n < 2 * SCAN_LEN; n++) begin
            if (n % 2 == 0) begin
                offer_sample((n % 4 == 0) ? 12'd4095 : 12'd0, 32'hFFFF_FFF6 + 32'(n));
            end else begin
                offer_sample(DIRECTED_KEPT[n / 2], 32'hFFFF_FFF6 + 32'(n));
            end
        end
        clock_ms = 32'hFFFF_FF00;
        run_phase(150, 0, 0, 1'b0);

        write_reg(CFG_THRESHOLD, 16'h0000);
        write_reg(CFG_VEL_TMO, 16'h0000);
        write_reg(CFG_REL_DEB, 16'h0000);
        write_reg(CFG_FULLSCALE, 16'hFFFF);
        run_phase(150, 52, 0, 1'b0);

        write_reg(CFG_THRESHOLD, 16'hFFFF);
        write_reg(CFG_VEL_TMO, 16'hFFFF);
        write_reg(CFG_REL_DEB, 16'hFFFF);
        write_reg(CFG_FULLSCALE, 16'h0000);
        run_phase(130, 0, 52, 1'b0);

        write_reg(CFG_THRESHOLD, 16'($urandom_range(0, 8000)));
        write_reg(CFG_VEL_TMO, 16'($urandom_range(0, 20)));
        write_reg(CFG_REL_DEB, 16'($urandom_range(0, 150)));
        write_reg(CFG_FULLSCALE, 16'($urandom_range(0, 65535)));
        run_phase(200, 35, 35, 1'b0);

        write_reg(CFG_THRESHOLD, 16'd50);
        write_reg(CFG_VEL_TMO, 16'd5);
        write_reg(CFG_REL_DEB, 16'd50);
        write_reg(CFG_FULLSCALE, 16'd4095);
        run_phase(150, 0, 0, 1'b1);

        $display("summary: %0d samples over %0d register settings, %0d results checked",
                 items_sent, phases_run, checked);
        $display("summary: %0d pad reports carried a latched strike velocity", strikes);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("timeout waiting for the scan sequencer");
        $display("end of test: mismatches");
        $finish;
    end

endmodule
